// ===== hw/rtl/tpac_pkg.sv =====
`default_nettype none
package tpac_pkg;

  localparam int COORD_W  = 16;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int MAG_W    = COORD_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 1;
  localparam int SIDE_RW  = (SUM_W + 1) / 2;
  localparam int PERIM_W  = 19;
  localparam int FACT_W   = 20;
  localparam int PROD1_W  = 2 * PERIM_W;
  localparam int HALF_W   = PROD1_W / 2;
  localparam int PART_W   = PROD1_W + HALF_W;
  localparam int PROD_W   = 2 * PROD1_W;
  localparam int AREA_W   = 32;
  localparam int AREA_RAD = 2 * AREA_W;
  localparam int SCALE_SH = 4;

  // carried alongside the area square root
  typedef struct packed {
    logic [PERIM_W-1:0] perimeter;
    logic               is_tri;
    logic               sat;
    logic               valid;
  } area_tag_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpac_sqrt_cell.sv =====
`default_nettype none
module tpac_sqrt_cell #(
  parameter int RW    = 17,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic [LANES-1:0][2*RW-1:0]      rad_i,
  input  wire logic [LANES-1:0][RW:0]          rem_i,
  input  wire logic [LANES-1:0][RW-1:0]        q_i,
  input  wire logic [TW-1:0]                   tag_i,
  output logic      [LANES-1:0][2*RW-1:0]      rad_o,
  output logic      [LANES-1:0][RW:0]          rem_o,
  output logic      [LANES-1:0][RW-1:0]        q_o,
  output logic      [TW-1:0]                   tag_o
);

  logic [LANES-1:0][RW+2:0]   rem_sh;
  logic [LANES-1:0][RW+2:0]   trial;
  logic [LANES-1:0][RW+2:0]   diff;
  logic [LANES-1:0]           ge;
  logic [LANES-1:0][2*RW-1:0] rad_nxt;
  logic [LANES-1:0][RW:0]     rem_nxt;
  logic [LANES-1:0][RW-1:0]   q_nxt;
  logic [LANES-1:0][2*RW-1:0] rad_r;
  logic [LANES-1:0][RW:0]     rem_r;
  logic [LANES-1:0][RW-1:0]   q_r;
  logic [TW-1:0]              tag_r;

  // one root bit per cell: bring down two radicand bits, try 4q+1
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem_sh[l]  = {rem_i[l], rad_i[l][2*RW-1 -: 2]};
      trial[l]   = {1'b0, q_i[l], 2'b01};
      diff[l]    = rem_sh[l] - trial[l];
      ge[l]      = rem_sh[l] >= trial[l];
      rem_nxt[l] = ge[l] ? diff[l][RW:0] : rem_sh[l][RW:0];
      q_nxt[l]   = {q_i[l][RW-2:0], ge[l]};
      rad_nxt[l] = {rad_i[l][2*RW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r <= rad_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_i;
    end
  end

  assign rad_o = rad_r;
  assign rem_o = rem_r;
  assign q_o   = q_r;
  assign tag_o = tag_r;

endmodule
`default_nettype wire

// ===== hw/rtl/tpac_sqrt.sv =====
`default_nettype none
module tpac_sqrt #(
  parameter int RW    = 17,
  parameter int LANES = 1,
  parameter int TW    = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic [LANES-1:0][2*RW-1:0] rad_i,
  input  wire logic [TW-1:0]              tag_i,
  output logic      [LANES-1:0][RW-1:0]   root_o,
  output logic      [TW-1:0]              tag_o
);

  logic [RW:0][LANES-1:0][2*RW-1:0] rad_w;
  logic [RW:0][LANES-1:0][RW:0]     rem_w;
  logic [RW:0][LANES-1:0][RW-1:0]   q_w;
  logic [RW:0][TW-1:0]              tag_w;

  assign rad_w[0] = rad_i;
  assign rem_w[0] = '0;
  assign q_w[0]   = '0;
  assign tag_w[0] = tag_i;

  for (genvar k = 0; k < RW; k++) begin : g_cell
    tpac_sqrt_cell #(.RW(RW), .LANES(LANES), .TW(TW)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .rad_i (rad_w[k]),
      .rem_i (rem_w[k]),
      .q_i   (q_w[k]),
      .tag_i (tag_w[k]),
      .rad_o (rad_w[k+1]),
      .rem_o (rem_w[k+1]),
      .q_o   (q_w[k+1]),
      .tag_o (tag_w[k+1])
    );
  end

  assign root_o = q_w[RW];
  assign tag_o  = tag_w[RW];

endmodule
`default_nettype wire

// ===== hw/rtl/triangle_perimeter_area_check.sv =====
// triangle perimeter and heron area, streaming
// input channel: in_valid/in_stall with six signed q8.8 vertex coordinates
// (in_ax, in_ay, in_bx, in_by_coord, in_cx, in_cy); a request is taken on a
// rising edge with in_valid high and in_stall low
// output channel: out_valid/out_stall with out_perimeter (q.8, sum of the
// floored side lengths), out_area (q.16 floor square root of heron's
// product, zero when the sides fail the strict triangle inequalities) and
// out_is_triangle
// every request gives exactly one result, formed along this path:
// three stages form differences, squares and sums, a row of 17 root cells
// finds the three sides together, four stages form the perimeter and the
// heron product, a row of 32 root cells finds the area, then the output
// register
// a new request is taken every cycle that in_stall is low; the whole pipeline moves as
// one and holds while a result is shown with out_stall high, which also raises
// in_stall in the same cycle
// reset empties the pipeline: out_valid is low in the cycle after reset
`default_nettype none
module triangle_perimeter_area_check (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_ax,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_ay,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_bx,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_by_coord,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_cx,
  input  wire logic [tpac_pkg::COORD_W-1:0]   in_cy,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [tpac_pkg::PERIM_W-1:0]   out_perimeter,
  output logic      [tpac_pkg::AREA_W-1:0]    out_area,
  output logic                                out_is_triangle
);

  import tpac_pkg::*;

  logic en;

  // stage 1: coordinate differences as magnitudes
  logic [DIFF_W-1:0] d_ax, d_ay, d_bx, d_by, d_cx, d_cy;
  logic [MAG_W-1:0]  m_ax_r, m_ay_r, m_bx_r, m_by_r, m_cx_r, m_cy_r;
  logic              v1_r;

  // stage 2 and 3: squares, then sums
  logic [SQ_W-1:0]   sq_ax_r, sq_ay_r, sq_bx_r, sq_by_r, sq_cx_r, sq_cy_r;
  logic              v2_r;
  logic [2:0][2*SIDE_RW-1:0] sum_r;
  logic              v3_r;

  // side roots
  logic [2:0][SIDE_RW-1:0] side;
  logic              side_v;

  // stage 4: perimeter and heron factors
  logic [PERIM_W-1:0] p;
  logic [FACT_W-1:0]  fa, fb, fc;
  logic               tri_ok;
  logic [PERIM_W-1:0] p4_r, fa_r, fb_r, fc_r;
  logic               tri4_r, v4_r;

  // stage 5 to 7: product p*fa*fb*fc
  logic [PROD1_W-1:0] m1_r, m2_r;
  logic [PERIM_W-1:0] p5_r;
  logic               tri5_r, v5_r;
  logic [PART_W-1:0]  pl_r, ph_r;
  logic [PERIM_W-1:0] p6_r;
  logic               tri6_r, v6_r;
  logic [PROD_W-1:0]  prod;
  logic [AREA_RAD-1:0] rad7_r;
  area_tag_t          tag7_r, tag_a;
  logic [0:0][AREA_W-1:0] area_root;

  logic               out_valid_r, out_tri_r;
  logic [PERIM_W-1:0] out_perim_r;
  logic [AREA_W-1:0]  out_area_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  assign d_ax = {in_bx[COORD_W-1], in_bx} - {in_cx[COORD_W-1], in_cx};
  assign d_ay = {in_by_coord[COORD_W-1], in_by_coord} - {in_cy[COORD_W-1], in_cy};
  assign d_bx = {in_ax[COORD_W-1], in_ax} - {in_cx[COORD_W-1], in_cx};
  assign d_by = {in_ay[COORD_W-1], in_ay} - {in_cy[COORD_W-1], in_cy};
  assign d_cx = {in_ax[COORD_W-1], in_ax} - {in_bx[COORD_W-1], in_bx};
  assign d_cy = {in_ay[COORD_W-1], in_ay} - {in_by_coord[COORD_W-1], in_by_coord};

  function automatic logic [MAG_W-1:0] absval(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] n;
    n = d[DIFF_W-1] ? (~d + 1'b1) : d;
    return n[MAG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_ax_r  <= absval(d_ax);
      m_ay_r  <= absval(d_ay);
      m_bx_r  <= absval(d_bx);
      m_by_r  <= absval(d_by);
      m_cx_r  <= absval(d_cx);
      m_cy_r  <= absval(d_cy);
      sq_ax_r <= m_ax_r * m_ax_r;
      sq_ay_r <= m_ay_r * m_ay_r;
      sq_bx_r <= m_bx_r * m_bx_r;
      sq_by_r <= m_by_r * m_by_r;
      sq_cx_r <= m_cx_r * m_cx_r;
      sq_cy_r <= m_cy_r * m_cy_r;
      sum_r[0] <= (2*SIDE_RW)'(sq_ax_r) + (2*SIDE_RW)'(sq_ay_r);
      sum_r[1] <= (2*SIDE_RW)'(sq_bx_r) + (2*SIDE_RW)'(sq_by_r);
      sum_r[2] <= (2*SIDE_RW)'(sq_cx_r) + (2*SIDE_RW)'(sq_cy_r);
    end
  end

  tpac_sqrt #(.RW(SIDE_RW), .LANES(3), .TW(1)) u_side_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .rad_i  (sum_r),
    .tag_i  (v3_r),
    .root_o (side),
    .tag_o  (side_v)
  );

  assign p  = PERIM_W'(side[0]) + PERIM_W'(side[1]) + PERIM_W'(side[2]);
  assign fa = FACT_W'(p) - {{(FACT_W-SIDE_RW-1){1'b0}}, side[0], 1'b0};
  assign fb = FACT_W'(p) - {{(FACT_W-SIDE_RW-1){1'b0}}, side[1], 1'b0};
  assign fc = FACT_W'(p) - {{(FACT_W-SIDE_RW-1){1'b0}}, side[2], 1'b0};
  assign tri_ok = !fa[FACT_W-1] && (fa != '0) && !fb[FACT_W-1] && (fb != '0)
               && !fc[FACT_W-1] && (fc != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      p4_r   <= p;
      fa_r   <= fa[PERIM_W-1:0];
      fb_r   <= fb[PERIM_W-1:0];
      fc_r   <= fc[PERIM_W-1:0];
      tri4_r <= tri_ok;
      m1_r   <= PROD1_W'(p4_r) * PROD1_W'(fa_r);
      m2_r   <= PROD1_W'(fb_r) * PROD1_W'(fc_r);
      p5_r   <= p4_r;
      tri5_r <= tri4_r;
      // 38x38 split into two 38x19 partial products
      pl_r   <= PART_W'(m1_r) * PART_W'(m2_r[HALF_W-1:0]);
      ph_r   <= PART_W'(m1_r) * PART_W'(m2_r[PROD1_W-1:HALF_W]);
      p6_r   <= p5_r;
      tri6_r <= tri5_r;
      rad7_r <= tri6_r ? prod[SCALE_SH +: AREA_RAD] : '0;
    end
  end

  assign prod = PROD_W'(pl_r) + (PROD_W'(ph_r) << HALF_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      tag7_r <= '0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= side_v;
      v5_r <= v4_r;
      v6_r <= v5_r;
      tag7_r.perimeter <= p6_r;
      tag7_r.is_tri    <= tri6_r;
      tag7_r.sat       <= tri6_r && (prod[PROD_W-1:SCALE_SH+AREA_RAD] != '0);
      tag7_r.valid     <= v6_r;
    end
  end

  tpac_sqrt #(.RW(AREA_W), .LANES(1), .TW($bits(area_tag_t))) u_area_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .rad_i  (rad7_r),
    .tag_i  (tag7_r),
    .root_o (area_root),
    .tag_o  (tag_a)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= tag_a.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_perim_r <= tag_a.perimeter;
      out_tri_r   <= tag_a.is_tri;
      out_area_r  <= tag_a.sat ? '1 : area_root[0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_perimeter   = out_perim_r;
  assign out_area        = out_area_r;
  assign out_is_triangle = out_tri_r;

  a_area_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_triangle |-> out_area == '0)
    else $error("area nonzero for a non-triangle");

  a_tri_perim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_triangle |-> out_perimeter != '0)
    else $error("triangle with zero perimeter");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule
`default_nettype wire
